### hdl/ihs_pkg.sv
// Shared types and constants for the image header sniffer.
`timescale 1ns / 1ps
package ihs_pkg;

  localparam int CaptureDepthDefault = 18;
  localparam int QueueDepth = 2;

  typedef enum logic [3:0] {
    FMT_ERR  = 4'd0,
    FMT_UNK  = 4'd1,
    FMT_BMP  = 4'd2,
    FMT_PNG  = 4'd3,
    FMT_GIF  = 4'd4,
    FMT_WEBP = 4'd5,
    FMT_QOI  = 4'd6,
    FMT_QOY  = 4'd7,
    FMT_JPG  = 4'd8,
    FMT_PCX  = 4'd9,
    FMT_ICO  = 4'd10,
    FMT_TGA  = 4'd11,
    FMT_ANI  = 4'd12
  } fmt_t;

  typedef enum logic [3:0] {
    PH_SIG,
    PH_HDR,
    PH_SKIP,
    PH_TAIL,
    PH_PNG_CHUNK,
    PH_PNG_IHDR,
    PH_JPG_LEN,
    PH_JPG_MARK,
    PH_JPG_SOF
  } phase_t;

  // One byte with its last flag, as queued by the front end.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [3:0]  format;
    logic [31:0] width;
    logic [31:0] height;
    logic [7:0]  channels;
    logic [15:0] bits_per_pixel;
    logic [7:0]  palette_bits;
  } result_t;

endpackage

### hdl/ihs_front.sv
// Input front end: accepts bytes and queues them for the parser.
`timescale 1ns / 1ps
module ihs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tlast,
  output logic                q_valid,
  input  logic                q_ready,
  output ihs_pkg::byte_item_t q_item
);

  ihs_pkg::byte_item_t mem_r [ihs_pkg::QueueDepth];
  logic                wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                push, pop;

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_item    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{data: in_tdata, last: in_tlast};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !pop) else $error("pop from empty queue");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 2'd1) else $error("queue count slip");

endmodule

### hdl/ihs_parse.sv
// Back end: header parser with its output register.
`timescale 1ns / 1ps
module ihs_parse #(
  parameter int CAPTURE_DEPTH = ihs_pkg::CaptureDepthDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  ihs_pkg::byte_item_t q_item,
  output logic                res_valid,
  input  logic                res_ready,
  output ihs_pkg::result_t    res
);

  localparam int CW = $clog2(CAPTURE_DEPTH);

  ihs_pkg::phase_t phase_r, phase_nxt;
  ihs_pkg::fmt_t   fmt_r, fmt_nxt;
  logic [7:0]      pos_r, pos_nxt;
  logic [32:0]     skip_r, skip_nxt;
  logic [7:0]      cap_r [CAPTURE_DEPTH];
  logic [7:0]      capn  [CAPTURE_DEPTH];
  logic [15:0]     mark_r, mark_nxt;
  logic            sent_r, sent_nxt;
  logic [31:0]     w_r, w_nxt, h_r, h_nxt;
  logic [7:0]      ch_r, ch_nxt, pal_r, pal_nxt;
  logic [15:0]     dp_r, dp_nxt;
  logic            ov_r;
  ihs_pkg::result_t out_r, out_nxt;
  logic            emit;
  logic [3:0]      efmt;
  logic            take;

  assign q_ready   = !ov_r || res_ready;
  assign take      = q_valid && q_ready;
  assign res_valid = ov_r;
  assign res       = out_r;

  function automatic logic [15:0] le16(input logic [7:0] a, input logic [7:0] b);
    le16 = {b, a};
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  always_comb begin
    logic [7:0]  b;
    logic [7:0]  p;
    logic [31:0] t32, hh;
    logic [15:0] v16;
    logic [7:0]  c0, c1, c2, c3;
    logic        fail;
    ihs_pkg::fmt_t f;
    b = q_item.data;
    p = pos_r;
    phase_nxt = phase_r; fmt_nxt = fmt_r; pos_nxt = pos_r; skip_nxt = skip_r;
    mark_nxt = mark_r; sent_nxt = sent_r;
    w_nxt = w_r; h_nxt = h_r; ch_nxt = ch_r; dp_nxt = dp_r; pal_nxt = pal_r;
    for (int i = 0; i < CAPTURE_DEPTH; i++) capn[i] = cap_r[i];
    emit = 1'b0; efmt = ihs_pkg::FMT_ERR; fail = 1'b0;
    t32 = '0; hh = '0; v16 = '0; f = ihs_pkg::FMT_UNK;
    c0 = '0; c1 = '0; c2 = '0; c3 = '0;
    if (!sent_r) begin
      if (phase_r == ihs_pkg::PH_SKIP) begin
        skip_nxt = skip_r - 33'd1;
        if (skip_nxt == '0) begin
          pos_nxt = '0;
          phase_nxt = (fmt_r == ihs_pkg::FMT_PNG) ? ihs_pkg::PH_PNG_CHUNK :
                      (fmt_r == ihs_pkg::FMT_JPG) ? ihs_pkg::PH_JPG_MARK :
                      ihs_pkg::PH_TAIL;
        end
      end else begin
        if (p < 8'(CAPTURE_DEPTH)) capn[p[CW-1:0]] = b;
        if (pos_r != 8'd255) pos_nxt = pos_r + 8'd1;
        c0 = capn[0]; c1 = capn[1]; c2 = capn[2]; c3 = capn[3];
        unique case (phase_r)
          ihs_pkg::PH_SIG: if (p == 8'd3) begin
            if (c0 == "B" && c1 == "M") f = ihs_pkg::FMT_BMP;
            else if ({c0, c1, c2, c3} == {8'h89, "PNG"}) f = ihs_pkg::FMT_PNG;
            else if ({c0, c1, c2, c3} == "GIF8") f = ihs_pkg::FMT_GIF;
            else if ({c0, c1, c2, c3} == "RIFF") f = ihs_pkg::FMT_WEBP;
            else if ({c0, c1, c2, c3} == "qoif") f = ihs_pkg::FMT_QOI;
            else if ({c0, c1, c2, c3} == "qoyf") f = ihs_pkg::FMT_QOY;
            else if (c0 == 8'hFF && c1 == 8'hD8) f = ihs_pkg::FMT_JPG;
            else if ({c0, c1, c2, c3} == 32'h0A050108) f = ihs_pkg::FMT_PCX;
            else if ({c0, c1, c2, c3} == 32'h00000100) f = ihs_pkg::FMT_ICO;
            if ((c2 == 8'd1 || c2 == 8'd9) && c1 == 8'd1) f = ihs_pkg::FMT_TGA;
            if ((c2 == 8'd2 || c2 == 8'd3 || c2 == 8'd10 || c2 == 8'd11) && c1 == 8'd0)
              f = ihs_pkg::FMT_TGA;
            fmt_nxt = f;
            if (f == ihs_pkg::FMT_UNK) begin
              emit = 1'b1; efmt = ihs_pkg::FMT_UNK;
            end else if (f == ihs_pkg::FMT_BMP) begin
              skip_nxt = 33'd10; phase_nxt = ihs_pkg::PH_SKIP;
            end else if (f == ihs_pkg::FMT_JPG) begin
              mark_nxt = {c3, c2}; phase_nxt = ihs_pkg::PH_JPG_LEN; pos_nxt = '0;
            end else begin
              phase_nxt = ihs_pkg::PH_HDR;
            end
          end
          ihs_pkg::PH_HDR: begin
            case (fmt_r)
              ihs_pkg::FMT_PNG: if (p == 8'd7) begin
                if ({capn[4], capn[5], capn[6], capn[7]} != 32'h0D0A1A0A) fail = 1'b1;
                else begin phase_nxt = ihs_pkg::PH_PNG_CHUNK; pos_nxt = '0; end
              end
              ihs_pkg::FMT_GIF: if (p == 8'd9) begin
                if (!((capn[4] == "7" || capn[4] == "9") && capn[5] == "a")) fail = 1'b1;
                else begin
                  w_nxt = {16'd0, le16(capn[6], capn[7])};
                  h_nxt = {16'd0, le16(capn[8], capn[9])};
                  dp_nxt = 16'd24; ch_nxt = 8'd3; pal_nxt = 8'd8;
                  emit = 1'b1; efmt = ihs_pkg::FMT_GIF;
                end
              end
              ihs_pkg::FMT_WEBP: begin
                t32 = {capn[12], capn[13], capn[14], capn[15]};
                if (p == 8'd11) begin
                  if ({capn[7], capn[6], capn[5], capn[4]} < 32'd8) fail = 1'b1;
                  else if ({capn[8], capn[9], capn[10], capn[11]} == "WEBP") emit = 1'b0;
                  else if ({capn[8], capn[9], capn[10], capn[11]} == "ACON") begin
                    emit = 1'b1; efmt = ihs_pkg::FMT_ANI;
                  end else begin
                    emit = 1'b1; efmt = ihs_pkg::FMT_UNK;
                  end
                end else if (p == 8'd15) begin
                  if (t32 == "VP8 " || t32 == "VP8L") begin
                    dp_nxt = 16'd24; ch_nxt = 8'd3;
                  end else if (t32 == "VP8X") begin
                    dp_nxt = 16'd32; ch_nxt = 8'd4;
                  end
                  emit = 1'b1; efmt = ihs_pkg::FMT_WEBP;
                end
              end
              ihs_pkg::FMT_QOI, ihs_pkg::FMT_QOY: if (p == 8'd13) begin
                if (capn[12] < 8'd3 || capn[12] > 8'd4 || capn[13] > 8'd1) fail = 1'b1;
                else begin
                  w_nxt = {capn[4], capn[5], capn[6], capn[7]};
                  h_nxt = {capn[8], capn[9], capn[10], capn[11]};
                  ch_nxt = capn[12];
                  dp_nxt = {5'd0, capn[12], 3'd0};
                  emit = 1'b1; efmt = fmt_r;
                end
              end
              ihs_pkg::FMT_PCX: if (p == 8'd11) begin
                w_nxt = sx16(le16(capn[8], capn[9])) - sx16(le16(capn[4], capn[5])) + 32'd1;
                h_nxt = sx16(le16(capn[10], capn[11])) - sx16(le16(capn[6], capn[7]))
                        + 32'd1;
                ch_nxt = 8'd3; dp_nxt = 16'd24;
                skip_nxt = 33'd53; phase_nxt = ihs_pkg::PH_SKIP;
              end
              ihs_pkg::FMT_ICO: if (p == 8'd13) begin
                if ((capn[4] == 8'd0 && capn[5] == 8'd0) || capn[9] != 8'd0) fail = 1'b1;
                else begin
                  w_nxt = (capn[6] != 8'd0) ? {24'd0, capn[6]} : 32'd256;
                  h_nxt = (capn[7] != 8'd0) ? {24'd0, capn[7]} : 32'd256;
                  ch_nxt = 8'd4; dp_nxt = 16'd32;
                  v16 = le16(capn[12], capn[13]);
                  pal_nxt = (v16 > 16'd8) ? 8'd0 : v16[7:0];
                  skip_nxt = 33'd8; phase_nxt = ihs_pkg::PH_SKIP;
                end
              end
              ihs_pkg::FMT_TGA: if (p == 8'd17) begin
                w_nxt = {16'd0, le16(capn[12], capn[13])};
                h_nxt = {16'd0, le16(capn[14], capn[15])};
                if (capn[1] == 8'd1 || capn[1] == 8'd9) begin
                  if (capn[16] != 8'd8) fail = 1'b1;
                  pal_nxt = 8'd8;
                  v16 = {8'd0, capn[7]};
                end else begin
                  v16 = {8'd0, capn[16]};
                end
                if (!fail) begin
                  dp_nxt = v16;
                  if (v16[2:0] == 3'd0 && v16 > 16'd16) ch_nxt = {3'd0, v16[7:3]};
                  else if (v16 == 16'd8) ch_nxt = 8'd1;
                  else ch_nxt = 8'd3;
                  emit = 1'b1; efmt = ihs_pkg::FMT_TGA;
                end
              end
              default: emit = 1'b0;
            endcase
          end
          ihs_pkg::PH_TAIL: begin
            v16 = le16(capn[14], capn[15]);
            if (fmt_r == ihs_pkg::FMT_PCX) begin
              if (capn[0] == 8'd1) begin
                pal_nxt = 8'd8; emit = 1'b1; efmt = ihs_pkg::FMT_PCX;
              end else if (capn[0] == 8'd3) begin
                emit = 1'b1; efmt = ihs_pkg::FMT_PCX;
              end else fail = 1'b1;
            end else if (p == 8'd15) begin
              if (fmt_r == ihs_pkg::FMT_BMP) begin
                w_nxt = {capn[7], capn[6], capn[5], capn[4]};
                h_nxt = {capn[11], capn[10], capn[9], capn[8]};
                if (v16 == 16'd16 || v16 == 16'd24 || v16 == 16'd32) begin
                  dp_nxt = v16;
                  ch_nxt = (v16 == 16'd16) ? 8'd3 : {3'd0, v16[7:3]};
                  emit = 1'b1; efmt = ihs_pkg::FMT_BMP;
                end else if (v16 == 16'd1 || v16 == 16'd4 || v16 == 16'd8) begin
                  dp_nxt = 16'd32; pal_nxt = v16[7:0]; ch_nxt = 8'd4;
                  emit = 1'b1; efmt = ihs_pkg::FMT_BMP;
                end else fail = 1'b1;
              end else begin
                if ({capn[3], capn[2], capn[1], capn[0]} == 32'd40) begin
                  w_nxt = {capn[7], capn[6], capn[5], capn[4]};
                  hh = {capn[11], capn[10], capn[9], capn[8]};
                  if (hh[31]) h_nxt = ~((~hh + 32'd1) >> 1) + 32'd1;
                  else h_nxt = hh >> 1;
                  pal_nxt = (v16[15] || v16 <= 16'd8) ? v16[7:0] : 8'd0;
                end
                emit = 1'b1; efmt = ihs_pkg::FMT_ICO;
              end
            end
          end
          ihs_pkg::PH_PNG_CHUNK: if (p == 8'd7) begin
            t32 = {capn[0], capn[1], capn[2], capn[3]};
            if ({capn[4], capn[5], capn[6], capn[7]} == "IHDR") begin
              if (t32 != 32'hD) fail = 1'b1;
              else begin phase_nxt = ihs_pkg::PH_PNG_IHDR; pos_nxt = '0; end
            end else begin
              skip_nxt = {1'b0, t32} + 33'd4; phase_nxt = ihs_pkg::PH_SKIP;
            end
          end
          ihs_pkg::PH_PNG_IHDR: if (p == 8'd9) begin
            w_nxt = {capn[0], capn[1], capn[2], capn[3]};
            h_nxt = {capn[4], capn[5], capn[6], capn[7]};
            case (capn[9])
              8'd0: ch_nxt = 8'd1;
              8'd2: ch_nxt = 8'd3;
              8'd3: begin ch_nxt = 8'd3; pal_nxt = capn[8]; end
              8'd4: ch_nxt = 8'd2;
              8'd6: ch_nxt = 8'd4;
              default: fail = 1'b1;
            endcase
            if (!fail) begin
              dp_nxt = (pal_nxt != 8'd0) ? 16'd24 : {8'd0, capn[8]} * {8'd0, ch_nxt};
              emit = 1'b1; efmt = ihs_pkg::FMT_PNG;
            end
          end
          ihs_pkg::PH_JPG_LEN: if (p == 8'd1) begin
            v16 = {capn[0], capn[1]};
            if (v16 < 16'd2) fail = 1'b1;
            else begin
              v16 = v16 - 16'd2;
              if (mark_r == 16'hC0FF || mark_r == 16'hC1FF || mark_r == 16'hC2FF) begin
                if (v16 < 16'd6) fail = 1'b1;
                else begin phase_nxt = ihs_pkg::PH_JPG_SOF; pos_nxt = '0; end
              end else if (v16 == 16'd0) begin
                phase_nxt = ihs_pkg::PH_JPG_MARK; pos_nxt = '0;
              end else begin
                skip_nxt = {17'd0, v16}; phase_nxt = ihs_pkg::PH_SKIP;
              end
            end
          end
          ihs_pkg::PH_JPG_MARK: if (p == 8'd1) begin
            mark_nxt = {capn[1], capn[0]}; phase_nxt = ihs_pkg::PH_JPG_LEN; pos_nxt = '0;
          end
          ihs_pkg::PH_JPG_SOF: if (p == 8'd5) begin
            h_nxt = {16'd0, capn[1], capn[2]};
            w_nxt = {16'd0, capn[3], capn[4]};
            ch_nxt = capn[5];
            dp_nxt = {8'd0, capn[5]} * {8'd0, capn[0]};
            emit = 1'b1; efmt = ihs_pkg::FMT_JPG;
          end
          default: emit = 1'b0;
        endcase
      end
      if (fail) begin
        emit = 1'b1; efmt = ihs_pkg::FMT_ERR;
      end
      // an ICO cut after its directory entry still reports the directory values
      if (q_item.last && !emit) begin
        emit = 1'b1;
        if (fmt_nxt == ihs_pkg::FMT_ICO &&
            (phase_nxt == ihs_pkg::PH_SKIP || phase_nxt == ihs_pkg::PH_TAIL)) begin
          efmt = ihs_pkg::FMT_ICO;
        end else begin
          efmt = ihs_pkg::FMT_ERR; fail = 1'b1;
        end
      end
      if (emit) sent_nxt = 1'b1;
    end
    out_nxt.format = efmt;
    if (fail) begin
      out_nxt.width = '0; out_nxt.height = '0; out_nxt.channels = '0;
      out_nxt.bits_per_pixel = '0; out_nxt.palette_bits = '0;
    end else begin
      out_nxt.width = w_nxt; out_nxt.height = h_nxt; out_nxt.channels = ch_nxt;
      out_nxt.bits_per_pixel = dp_nxt; out_nxt.palette_bits = pal_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (take && emit) begin
      ov_r <= 1'b1;
    end else if (res_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && q_item.last)) begin
      phase_r <= ihs_pkg::PH_SIG;
      fmt_r   <= ihs_pkg::FMT_UNK;
      pos_r   <= '0;
      skip_r  <= '0;
      mark_r  <= '0;
      sent_r  <= 1'b0;
      w_r <= '0; h_r <= '0; ch_r <= '0; dp_r <= '0; pal_r <= '0;
      for (int i = 0; i < CAPTURE_DEPTH; i++) cap_r[i] <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      fmt_r   <= fmt_nxt;
      pos_r   <= pos_nxt;
      skip_r  <= skip_nxt;
      mark_r  <= mark_nxt;
      sent_r  <= sent_nxt;
      w_r <= w_nxt; h_r <= h_nxt; ch_r <= ch_nxt; dp_r <= dp_nxt; pal_r <= pal_nxt;
      for (int i = 0; i < CAPTURE_DEPTH; i++) cap_r[i] <= capn[i];
    end
  end

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    take && sent_r |-> !emit) else $error("second result for one file");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_r.format == ihs_pkg::FMT_ERR |-> out_r.width == '0 && out_r.channels == '0)
    else $error("error result carries data");
  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == ihs_pkg::PH_SKIP && !sent_r |-> skip_r != '0) else $error("empty skip");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !res_ready |=> ov_r && $stable(out_r)) else $error("result lost");

endmodule

### hdl/image_header_sniffer.sv
// Top level of the image header sniffer.
`timescale 1ns / 1ps
// Image header sniffer: feed an image file one byte per item on the in_ channel,
// in_tlast high on the file's final byte. The first four bytes choose the format
// (BMP, PNG, GIF, WebP/ANI, QOI/QOY, JPEG, PCX, ICO, TGA); the header is then
// walked, PNG chunks and JPEG segments being skipped byte by byte.
// One result item per file leaves on the out_ channel as soon as the header is
// decoded, or at the last byte (error, or ICO directory values) if it ends early.
// Bytes after the result are dropped until in_tlast; the next byte opens a file.
// Throughput: one byte per cycle sustained while no result waits; the parser
// updates counters and a small capture array per byte. With the queue empty, a
// byte that completes a result is first written to the input queue; the parser
// takes it from there and loads the output register, which drives out_tvalid.
// The two-entry input queue decouples the byte source from the parser, and the
// output register holds a result while out_tready is low; the parser then stalls
// on every byte until the result is taken, and the queue fills and drops in_tready.
// Reset (rst_n low, synchronous) empties the queue, drops any pending result
// and returns the parser to waiting for a signature.
module image_header_sniffer #(
  parameter int CAPTURE_DEPTH = ihs_pkg::CaptureDepthDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [3:0] format, [35:4] width, [67:36] height, [75:68] channels,
  // [91:76] bits_per_pixel, [99:92] palette_bits, [103:100] zero
  output logic [103:0] out_tdata
);

  logic                q_valid, q_ready;
  ihs_pkg::byte_item_t q_item;
  ihs_pkg::result_t    res;

  ihs_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .q_valid, .q_ready, .q_item
  );

  ihs_parse #(.CAPTURE_DEPTH(CAPTURE_DEPTH)) u_parse (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .res_valid(out_tvalid), .res_ready(out_tready), .res
  );

  assign out_tdata = {4'd0, res.palette_bits, res.bits_per_pixel, res.channels,
                      res.height, res.width, res.format};

endmodule
